// ===== src/ruci_pkg.sv =====
// ----------------------------------------------------------------------------
// ruci_pkg
// Shared constants, tables, types and helpers of the ray and unit cube
// intersection pipeline.
// ----------------------------------------------------------------------------
package ruci_pkg;

	localparam int COORD_FRAC_BITS = 12;
	localparam int F      = COORD_FRAC_BITS;
	localparam int HALF   = 1 << (F - 1);
	localparam int IN_W   = 16;
	localparam int DEN_W  = 16;
	localparam int NUM_W  = ((F > 16) ? F : 16) + 1;
	localparam int PD_W   = NUM_W + IN_W;
	localparam int PN_W   = IN_W + DEN_W + 1;
	localparam int X_W    = NUM_W - 1 + DEN_W;
	localparam int V_W    = NUM_W + IN_W + 1;
	localparam int T_FRAC = 12;
	localparam int T_W    = 24;
	localparam int DQ_W   = NUM_W + 12;
	localparam int DVS_W  = DEN_W + 1;
	localparam int REM_W  = DVS_W + DQ_W;
	localparam int CRD_W  = F + 3;
	localparam int NFACE  = 6;

	localparam logic [T_W-1:0] T_MAX = '1;

	localparam logic [2:0] FACE_POS_Y = 3'd0;
	localparam logic [2:0] FACE_NEG_Y = 3'd1;
	localparam logic [2:0] FACE_POS_Z = 3'd2;
	localparam logic [2:0] FACE_NEG_Z = 3'd3;
	localparam logic [2:0] FACE_POS_X = 3'd4;
	localparam logic [2:0] FACE_NEG_X = 3'd5;

	// Axis of each face (0 x, 1 y, 2 z) and whether it is the positive face.
	localparam int FACE_AXIS [NFACE] = '{1, 1, 2, 2, 0, 0};
	localparam bit FACE_UP [NFACE] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
	// Indexed by face axis, then by other axis: set for a strict bound.
	localparam bit STRICT [3][3] = '{'{1'b0, 1'b0, 1'b1}, '{1'b1, 1'b0, 1'b1},
		'{1'b0, 1'b0, 1'b0}};

	typedef struct packed {
		logic [NFACE-1:0] hit;
		logic [NFACE-1:0][NFACE-1:0] ahead;
		logic [NFACE-1:0][NUM_W-2:0] num;
		logic [2:0][DEN_W-1:0] den;
		logic [NFACE-1:0][2:0][V_W-1:0] v;
	} cand_t;

	typedef struct packed {
		logic hv;
		logic last;
		logic [2:0] face;
		logic [DVS_W-1:0] dvs;
		logic [3:0][REM_W-1:0] rem;
		logic [3:0][DQ_W-1:0] q;
	} div_rec_t;

	function automatic logic [15:0] sat16(input logic signed [31:0] v);
		logic [15:0] r;
		if (v > 32'sd32767) begin
			r = 16'h7fff;
		end else if (v < -32'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ===== src/ruci_front.sv =====
// ----------------------------------------------------------------------------
// ruci_front
// Four pipeline stages: input registers, plane parameters, products, and the
// bound tests with the pairwise ordering of candidate faces.
// ----------------------------------------------------------------------------
module ruci_front (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_vld,
	input  logic signed [15:0] origin_x,
	input  logic signed [15:0] origin_y,
	input  logic signed [15:0] origin_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	output logic vld_s4,
	output ruci_pkg::cand_t cand_s4
);

	logic vld_s1, vld_s2, vld_s3;
	logic signed [15:0] p_s1 [3];
	logic signed [15:0] d_s1 [3];
	logic signed [15:0] p_s2 [3];
	logic signed [15:0] d_s2 [3];
	logic [ruci_pkg::DEN_W-1:0] den_s2 [3];
	logic [ruci_pkg::DEN_W-1:0] den_s3 [3];
	logic [ruci_pkg::NUM_W-2:0] num_s2 [ruci_pkg::NFACE];
	logic [ruci_pkg::NUM_W-2:0] num_s3 [ruci_pkg::NFACE];
	logic [ruci_pkg::NFACE-1:0] cand_s2, cand_s3;
	logic signed [ruci_pkg::PD_W-1:0] pd_s3 [ruci_pkg::NFACE][3];
	logic signed [ruci_pkg::PN_W-1:0] pn_s3 [3][3];
	logic [ruci_pkg::X_W-1:0] x_s3 [ruci_pkg::NFACE][3];

	logic [ruci_pkg::DEN_W-1:0] den_c [3];
	logic [ruci_pkg::NUM_W-2:0] num_c [ruci_pkg::NFACE];
	logic [ruci_pkg::NFACE-1:0] cand_c;
	ruci_pkg::cand_t cand_c4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_comb begin
		logic signed [ruci_pkg::NUM_W-1:0] pe;
		logic signed [ruci_pkg::NUM_W-1:0] nm;
		logic flip;
		int a;
		for (int i = 0; i < 3; i++) begin
			den_c[i] = d_s1[i][15] ? ruci_pkg::DEN_W'(-d_s1[i]) : ruci_pkg::DEN_W'(d_s1[i]);
		end
		for (int f = 0; f < ruci_pkg::NFACE; f++) begin
			a = ruci_pkg::FACE_AXIS[f];
			pe = ruci_pkg::NUM_W'(p_s1[a]);
			if (ruci_pkg::FACE_UP[f]) begin
				nm = ruci_pkg::NUM_W'(ruci_pkg::HALF) - pe;
				flip = d_s1[a][15];
			end else begin
				nm = ruci_pkg::NUM_W'(ruci_pkg::HALF) + pe;
				flip = (d_s1[a] != 16'sd0) && !d_s1[a][15];
			end
			if (flip) begin
				nm = -nm;
			end
			cand_c[f] = (d_s1[a] != 16'sd0) && !nm[ruci_pkg::NUM_W-1];
			num_c[f] = nm[ruci_pkg::NUM_W-2:0];
		end
	end

	always_comb begin
		logic signed [ruci_pkg::V_W-1:0] vv;
		logic signed [ruci_pkg::V_W-1:0] h;
		logic ok;
		int a;
		int b;
		cand_c4 = '0;
		for (int f = 0; f < ruci_pkg::NFACE; f++) begin
			a = ruci_pkg::FACE_AXIS[f];
			h = $signed(ruci_pkg::V_W'(den_s3[a]) << (ruci_pkg::F - 1));
			ok = cand_s3[f];
			for (int k = 0; k < 3; k++) begin
				vv = ruci_pkg::V_W'(pn_s3[a][k]) + ruci_pkg::V_W'(pd_s3[f][k]);
				cand_c4.v[f][k] = vv;
				if (k != a) begin
					if (ruci_pkg::STRICT[a][k]) begin
						ok = ok && (vv > -h) && (vv < h);
					end else begin
						ok = ok && (vv >= -h) && (vv <= h);
					end
				end
			end
			cand_c4.hit[f] = ok;
			cand_c4.num[f] = num_s3[f];
			for (int g = 0; g < ruci_pkg::NFACE; g++) begin
				b = ruci_pkg::FACE_AXIS[g];
				cand_c4.ahead[f][g] = (x_s3[g][a] < x_s3[f][b]) ||
					((x_s3[g][a] == x_s3[f][b]) && (g < f));
			end
		end
		for (int i = 0; i < 3; i++) begin
			cand_c4.den[i] = den_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= origin_x;
			p_s1[1] <= origin_y;
			p_s1[2] <= origin_z;
			d_s1[0] <= dir_x;
			d_s1[1] <= dir_y;
			d_s1[2] <= dir_z;
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= p_s1[i];
				d_s2[i] <= d_s1[i];
				den_s2[i] <= den_c[i];
				den_s3[i] <= den_s2[i];
			end
			cand_s2 <= cand_c;
			cand_s3 <= cand_s2;
			for (int f = 0; f < ruci_pkg::NFACE; f++) begin
				num_s2[f] <= num_c[f];
				num_s3[f] <= num_s2[f];
				for (int k = 0; k < 3; k++) begin
					pd_s3[f][k] <= $signed({1'b0, num_s2[f]}) * d_s2[k];
					x_s3[f][k] <= num_s2[f] * den_s2[k];
				end
			end
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					pn_s3[a][k] <= p_s2[k] * $signed({1'b0, den_s2[a]});
				end
			end
			cand_s4 <= cand_c4;
		end
	end

endmodule

// ===== src/ruci_serial.sv =====
// ----------------------------------------------------------------------------
// ruci_serial
// Ranks the hit faces of one ray by t and hands them out one per cycle while
// en is high, building the dividends for the divider pipeline.
// ----------------------------------------------------------------------------
module ruci_serial (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_s4,
	input  ruci_pkg::cand_t cand_s4,
	output logic adv,
	output logic rec_vld,
	output ruci_pkg::div_rec_t rec
);

	logic ser_vld_q;
	logic [2:0] idx_q;
	logic [2:0] n_q;
	logic [2:0] rank_q [ruci_pkg::NFACE];
	ruci_pkg::cand_t c_q;

	logic [2:0] rank_c [ruci_pkg::NFACE];
	logic [2:0] n_c;
	logic last_now;

	always_comb begin
		n_c = '0;
		for (int f = 0; f < ruci_pkg::NFACE; f++) begin
			n_c = n_c + 3'(cand_s4.hit[f]);
			rank_c[f] = '0;
			for (int g = 0; g < ruci_pkg::NFACE; g++) begin
				rank_c[f] = rank_c[f] + 3'(cand_s4.hit[g] && cand_s4.ahead[f][g]);
			end
		end
	end

	assign last_now = (n_q == 3'd0) || (idx_q == 3'(n_q - 3'd1));
	assign adv = en && (!ser_vld_q || last_now);
	assign rec_vld = ser_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			idx_q <= '0;
		end else if (adv) begin
			ser_vld_q <= vld_s4;
			idx_q <= '0;
		end else if (ser_vld_q && en) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_q <= cand_s4;
			n_q <= n_c;
			for (int f = 0; f < ruci_pkg::NFACE; f++) begin
				rank_q[f] <= rank_c[f];
			end
		end
	end

	always_comb begin
		logic [2:0] pf;
		logic [ruci_pkg::NUM_W-2:0] pnum;
		logic [ruci_pkg::DEN_W-1:0] pden;
		logic [ruci_pkg::V_W-1:0] pv [3];
		pf = '0;
		pnum = '0;
		pden = '0;
		for (int k = 0; k < 3; k++) begin
			pv[k] = '0;
		end
		for (int f = 0; f < ruci_pkg::NFACE; f++) begin
			if (c_q.hit[f] && (rank_q[f] == idx_q)) begin
				pf = 3'(f);
				pnum = c_q.num[f];
				pden = c_q.den[ruci_pkg::FACE_AXIS[f]];
				for (int k = 0; k < 3; k++) begin
					pv[k] = c_q.v[f][k];
				end
			end
		end
		rec.hv = (n_q != 3'd0);
		rec.last = last_now;
		rec.face = pf;
		rec.dvs = {pden, 1'b0};
		rec.q = '0;
		rec.rem[0] = (ruci_pkg::REM_W'(pnum) << (ruci_pkg::T_FRAC + 1)) +
			ruci_pkg::REM_W'(pden);
		for (int k = 0; k < 3; k++) begin
			rec.rem[k + 1] = (ruci_pkg::REM_W'($signed(pv[k])) << 1) +
				(ruci_pkg::REM_W'(pden) << ruci_pkg::F) +
				(ruci_pkg::REM_W'(pden) << 1) + ruci_pkg::REM_W'(pden);
		end
	end

endmodule

// ===== src/ruci_divider.sv =====
// ----------------------------------------------------------------------------
// ruci_divider
// Pipelined restoring divider, one quotient bit per stage, four lanes
// sharing one divisor: t and the three hit coordinates.
// ----------------------------------------------------------------------------
module ruci_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  ruci_pkg::div_rec_t in_rec,
	output logic out_vld,
	output ruci_pkg::div_rec_t out_rec
);

	logic vld_sn [ruci_pkg::DQ_W+1];
	ruci_pkg::div_rec_t rec_sn [ruci_pkg::DQ_W+1];
	ruci_pkg::div_rec_t nxt [ruci_pkg::DQ_W];

	always_comb begin
		logic [ruci_pkg::REM_W-1:0] sh;
		for (int s = 0; s < ruci_pkg::DQ_W; s++) begin
			nxt[s] = rec_sn[s];
			sh = ruci_pkg::REM_W'(rec_sn[s].dvs) << (ruci_pkg::DQ_W - 1 - s);
			for (int l = 0; l < 4; l++) begin
				if (rec_sn[s].rem[l] >= sh) begin
					nxt[s].rem[l] = rec_sn[s].rem[l] - sh;
					nxt[s].q[l][ruci_pkg::DQ_W-1-s] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= ruci_pkg::DQ_W; s++) begin
				vld_sn[s] <= 1'b0;
			end
		end else if (en) begin
			vld_sn[0] <= in_vld;
			for (int s = 0; s < ruci_pkg::DQ_W; s++) begin
				vld_sn[s + 1] <= vld_sn[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_sn[0] <= in_rec;
			for (int s = 0; s < ruci_pkg::DQ_W; s++) begin
				rec_sn[s + 1] <= nxt[s];
			end
		end
	end

	assign out_vld = vld_sn[ruci_pkg::DQ_W];
	assign out_rec = rec_sn[ruci_pkg::DQ_W];

endmodule

// ===== src/ray_unit_cube_intersect.sv =====
// Path from ray to first result: the front stages, the serializer
// register, the one-bit-per-stage divider pipeline and the output register.
// Throughput: one result per cycle while res_stall is low; a ray yields
// max(1, hits) results, handed out in order of t by the serializer.
// Reset: arst_n clears all valid bits and the serializer index; data registers are not reset.
// ----------------------------------------------------------------------------
// ray_unit_cube_intersect
// Ray against the unit cube: ordered face hits with t and hit point.
// ----------------------------------------------------------------------------
module ray_unit_cube_intersect (
	input  logic clk,
	input  logic arst_n,
	input  logic ray_valid,
	output logic ray_stall,
	input  logic signed [15:0] origin_x,
	input  logic signed [15:0] origin_y,
	input  logic signed [15:0] origin_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	output logic res_valid,
	input  logic res_stall,
	output logic hit_valid,
	output logic [23:0] hit_t,
	output logic signed [15:0] hit_x,
	output logic signed [15:0] hit_y,
	output logic signed [15:0] hit_z,
	output logic [2:0] face,
	output logic last
);

	logic en, adv, vld_s4, rec_vld, div_vld;
	ruci_pkg::cand_t cand_s4;
	ruci_pkg::div_rec_t rec, div_rec;

	logic res_valid_q, hit_valid_q, last_q;
	logic [23:0] hit_t_q;
	logic [15:0] crd_q [3];
	logic [2:0] face_q;

	logic [ruci_pkg::T_W-1:0] t_c;
	logic [15:0] crd_c [3];

	assign en = !res_valid_q || !res_stall;
	assign ray_stall = !adv;

	ruci_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(ray_valid),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.vld_s4(vld_s4), .cand_s4(cand_s4)
	);

	ruci_serial u_serial (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_s4(vld_s4), .cand_s4(cand_s4),
		.adv(adv), .rec_vld(rec_vld), .rec(rec)
	);

	ruci_divider u_divider (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(rec_vld), .in_rec(rec),
		.out_vld(div_vld), .out_rec(div_rec)
	);

	always_comb begin
		logic signed [ruci_pkg::CRD_W-1:0] c;
		if (div_rec.q[0] > ruci_pkg::DQ_W'(ruci_pkg::T_MAX)) begin
			t_c = ruci_pkg::T_MAX;
		end else begin
			t_c = div_rec.q[0][ruci_pkg::T_W-1:0];
		end
		for (int k = 0; k < 3; k++) begin
			c = $signed({1'b0, div_rec.q[k + 1][ruci_pkg::F+1:0]}) -
				ruci_pkg::CRD_W'(ruci_pkg::HALF + 1);
			crd_c[k] = ruci_pkg::sat16(32'(c));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_valid_q <= div_rec.hv;
			last_q <= div_rec.last;
			hit_t_q <= div_rec.hv ? t_c : '0;
			face_q <= div_rec.hv ? div_rec.face : ruci_pkg::FACE_POS_Y;
			for (int k = 0; k < 3; k++) begin
				crd_q[k] <= div_rec.hv ? crd_c[k] : '0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign hit_valid = hit_valid_q;
	assign hit_t = hit_t_q;
	assign hit_x = crd_q[0];
	assign hit_y = crd_q[1];
	assign hit_z = crd_q[2];
	assign face = face_q;
	assign last = last_q;

`ifndef NO_ASSERTIONS
	a_nohit_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !hit_valid |-> last && (hit_t == '0) && (face == ruci_pkg::FACE_POS_Y))
		else $error("no-hit item is not a clean final item");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && hit_valid |-> face <= ruci_pkg::FACE_NEG_X)
		else $error("hit item carries an unknown face code");

	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> ray_stall)
		else $error("ray taken while the result side is stalled");
`endif

endmodule
